// ===== hw/rtl/frame_rate_meter_smoothed_top_assert.svh =====
// Assertion macros for the frame rate meter.
`ifndef FRAME_RATE_METER_SMOOTHED_TOP_ASSERT_SVH
`define FRAME_RATE_METER_SMOOTHED_TOP_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define FRMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("frame rate meter assertion failed");

// antecedent holds -> consequent in the next cycle
`define FRMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("frame rate meter assertion failed");

`endif

// ===== hw/rtl/frms_pkg.sv =====
// Shared constants for the frame rate meter.
`default_nettype none

package frms_pkg;

	// window length, a power of two so the average is a shift
	localparam int WINDOW_LEN = 64;
	localparam int WIN_AW     = $clog2(WINDOW_LEN);

	localparam int TS_W       = 32;
	localparam int INTERVAL_W = 16;
	localparam int SUM_W      = INTERVAL_W + WIN_AW;
	localparam int RATE_W     = 10;
	localparam int TPS_W      = 16;
	localparam int COUNT_W    = 8;
	localparam int DIV_CNT_W  = $clog2(TPS_W);

	localparam int S_DATA_W   = 32;
	localparam int M_DATA_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_CAP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TPS      = 1'b1;

	localparam logic [RATE_W-1:0]  RATE_RESET = 10'd60;
	localparam logic [TPS_W-1:0]   TPS_RESET  = 16'd1000;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

endpackage

`default_nettype wire

// ===== hw/rtl/frame_rate_meter_smoothed_top.sv =====
// Top level of the smoothed frame rate meter.
`default_nettype none

`include "frame_rate_meter_smoothed_top_assert.svh"

// Frame rate meter: each input transfer carries a frame timestamp; the block
// saturates the interval since the previous frame to 16 bits, keeps a 64-entry
// moving window of intervals in RAM with a running sum, divides
// ticks_per_second by the window average and steps the shown rate toward that
// raw rate with hysteresis, capped by rate_cap. Every input gives exactly one
// output transfer. The block takes one frame at a time: a frame passes through
// the window RAM read, the sum update, 16 steps of the restoring divider, the
// hysteresis update and the output load, which waits while an earlier result
// is still held. When the average is zero no division or hysteresis update
// runs. The output register lets a new frame start while a
// result still waits. After reset the window reads as all zero through
// per-entry valid bits; no clearing pass is needed.
module frame_rate_meter_smoothed_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [frms_pkg::S_DATA_W-1:0]      s_tdata,   // [31:0] timestamp
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [frms_pkg::M_DATA_W-1:0]      m_tdata,   // [9:0] shown_rate, zero pad
	input  wire logic                               cfg_we,
	input  wire logic [frms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [frms_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RD     = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_FOLLOW = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	localparam int IW  = frms_pkg::INTERVAL_W;
	localparam int SW  = frms_pkg::SUM_W;
	localparam int AW  = frms_pkg::WIN_AW;
	localparam int RW  = frms_pkg::RATE_W;
	localparam int TW  = frms_pkg::TPS_W;
	localparam int CW  = frms_pkg::COUNT_W;
	localparam int DCW = frms_pkg::DIV_CNT_W;

	localparam logic [AW-1:0]  HEAD_LAST = AW'(frms_pkg::WINDOW_LEN - 1);
	localparam logic [DCW-1:0] DIV_LAST  = DCW'(TW - 1);

	logic [2:0]                    state_q;
	logic [RW-1:0]                 rate_cap_q;
	logic [TW-1:0]                 tps_q;
	logic [frms_pkg::TS_W-1:0]     prev_time_q;
	logic [AW-1:0]                 head_q;
	logic [frms_pkg::WINDOW_LEN-1:0] valid_q;
	logic [SW-1:0]                 sum_q;
	logic [IW-1:0]                 delta_q;
	logic [RW-1:0]                 disp_q;
	logic [RW-1:0]                 stable_q;
	logic [CW-1:0]                 diff_q;
	logic [TW-1:0]                 rem_q;
	logic [TW-1:0]                 den_q;
	logic [TW-1:0]                 quo_q;
	logic [DCW-1:0]                div_cnt_q;
	logic                          m_tvalid_q;
	logic [RW-1:0]                 m_rate_q;

	logic                          accept;
	logic [frms_pkg::TS_W-1:0]     time_diff;
	logic [IW-1:0]                 delta_sat;
	logic [IW-1:0]                 ram_rdata;
	logic [IW-1:0]                 old_entry;
	logic [SW-1:0]                 sum_next;
	logic [TW-1:0]                 avg_next;
	logic                          ram_we;
	logic [TW:0]                   trial;
	logic                          trial_ge;

	logic                          rate_eq;
	logic                          reseat;
	logic [RW-1:0]                 stable_eff;
	logic [CW-1:0]                 count_eff;
	logic [CW-1:0]                 count_next;
	logic [RW:0]                   stepped;
	logic [RW-1:0]                 disp_next;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(frms_pkg::M_DATA_W - RW){1'b0}}, m_rate_q};

	assign time_diff = s_tdata - prev_time_q;
	assign delta_sat = (|time_diff[frms_pkg::TS_W-1:IW]) ? {IW{1'b1}} : time_diff[IW-1:0];

	assign ram_we    = (state_q == ST_RD);
	assign old_entry = valid_q[head_q] ? ram_rdata : '0;
	assign sum_next  = sum_q - SW'(old_entry) + SW'(delta_q);
	assign avg_next  = sum_next[SW-1:AW];

	assign trial    = {rem_q, quo_q[TW-1]};
	assign trial_ge = (trial >= {1'b0, den_q});

	always_comb begin
		rate_eq    = ({{(TW - RW){1'b0}}, disp_q} == quo_q);
		reseat     = (stable_q != disp_q);
		stable_eff = reseat ? disp_q : stable_q;
		count_eff  = reseat ? '0 : diff_q;
		if (({{(TW - RW){1'b0}}, stable_eff} != quo_q) && (count_eff != frms_pkg::COUNT_MAX)) begin
			count_next = count_eff + CW'(1);
		end else begin
			count_next = count_eff;
		end
		if ({{(TW - RW){1'b0}}, disp_q} > quo_q) begin
			stepped = {1'b0, disp_q} - (RW+1)'(1);
		end else begin
			stepped = {1'b0, disp_q} + (RW+1)'(1);
		end
		disp_next = (stepped > {1'b0, rate_cap_q}) ? rate_cap_q : stepped[RW-1:0];
	end

	frms_ram #(
		.WIDTH(IW),
		.DEPTH(frms_pkg::WINDOW_LEN)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (delta_q),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_cap_q <= frms_pkg::RATE_RESET;
			tps_q      <= frms_pkg::TPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frms_pkg::REG_RATE_CAP: rate_cap_q <= cfg_wdata[RW-1:0];
				frms_pkg::REG_TPS:      tps_q      <= cfg_wdata[TW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_time_q <= '0;
			head_q      <= '0;
			valid_q     <= '0;
			sum_q       <= '0;
			disp_q      <= frms_pkg::RATE_RESET;
			stable_q    <= frms_pkg::RATE_RESET;
			diff_q      <= '0;
			div_cnt_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_time_q <= s_tdata;
						state_q     <= ST_RD;
					end
				end
				ST_RD: begin
					sum_q           <= sum_next;
					valid_q[head_q] <= 1'b1;
					head_q          <= (head_q == HEAD_LAST) ? '0 : head_q + AW'(1);
					div_cnt_q       <= '0;
					state_q         <= (avg_next == '0) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_FOLLOW;
					end
				end
				ST_FOLLOW: begin
					if (!rate_eq) begin
						stable_q <= stable_eff;
						diff_q   <= count_next;
						if (count_next > CW'(1)) begin
							disp_q <= disp_next;
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= delta_sat;
		end
		if (state_q == ST_RD) begin
			rem_q <= '0;
			den_q <= avg_next;
			quo_q <= tps_q;
		end else if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? TW'(trial - {1'b0, den_q}) : trial[TW-1:0];
			quo_q <= {quo_q[TW-2:0], trial_ge};
		end
		if ((state_q == ST_OUT) && (!m_tvalid_q || m_tready)) begin
			m_rate_q <= disp_q;
		end
	end

	`FRMS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !s_tready)
	`FRMS_ASSERT_NEXT(a_div_to_follow, clk, arst_n,
		(state_q == ST_DIV) && (div_cnt_q == DIV_LAST), state_q == ST_FOLLOW)
	`FRMS_ASSERT_NEXT(a_step_capped, clk, arst_n,
		(state_q == ST_FOLLOW) && !rate_eq && (count_next > CW'(1)) && !cfg_we,
		disp_q <= rate_cap_q)
	`FRMS_ASSERT_NOW(a_out_load_free, clk, arst_n,
		(state_q == ST_OUT) && m_tvalid_q && !m_tready, !s_tready)

endmodule

`default_nettype wire

// ===== hw/rtl/frms_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module frms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the smoothed frame rate meter.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import frms_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} pacing_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	frame_rate_meter_smoothed_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [INTERVAL_W-1:0] iv_ring [WINDOW_LEN];
	int unsigned ring_pos;
	logic [SUM_W-1:0] iv_sum;
	logic [TS_W-1:0] last_ts;
	logic [RATE_W-1:0] disp_rate;
	logic [RATE_W-1:0] settled_rate;
	logic [COUNT_W-1:0] diff_count;
	logic [RATE_W-1:0] cap_reg;
	logic [TPS_W-1:0] tps_reg;

	logic [TS_W-1:0] frames_pending [$];
	logic [RATE_W-1:0] rates_due [$];
	logic [RATE_W-1:0] due_rate;
	logic [TS_W-1:0] gen_ts;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int results_checked = 0;
	int settings_used = 0;
	int unsigned cycle_count = 0;

	function automatic logic [RATE_W-1:0] predict_rate(input logic [TS_W-1:0] ts);
		logic [TS_W-1:0] delta;
		logic [INTERVAL_W-1:0] iv;
		logic [SUM_W-1:0] avg;
		logic [31:0] raw;
		logic [RATE_W:0] stepped;
		delta = ts - last_ts;
		iv = (delta > 32'h0000_FFFF) ? 16'hFFFF : delta[INTERVAL_W-1:0];
		last_ts = ts;
		iv_sum = iv_sum - iv_ring[ring_pos] + iv;
		iv_ring[ring_pos] = iv;
		ring_pos = (ring_pos + 1) % WINDOW_LEN;
		avg = iv_sum / WINDOW_LEN;
		if (avg != 0) begin
			raw = tps_reg / avg;
			if (disp_rate != raw) begin
				if (settled_rate != disp_rate) begin
					settled_rate = disp_rate;
					diff_count = '0;
				end
				if (raw != settled_rate && diff_count < COUNT_MAX)
					diff_count = diff_count + 1'b1;
				if (diff_count > 1) begin
					if (disp_rate > raw)
						stepped = disp_rate - 1'b1;
					else
						stepped = disp_rate + 1'b1;
					if (stepped > cap_reg)
						stepped = cap_reg;
					disp_rate = stepped[RATE_W-1:0];
				end
			end
		end
		return disp_rate;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RATE_CAP)
			cap_reg = val[RATE_W-1:0];
		else
			tps_reg = val[TPS_W-1:0];
	endtask

	task automatic wait_drained();
		while (frames_pending.size() != 0 || rates_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_pacing(input pacing_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 83;
				recv_idle_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_idle_pct = 83;
			end
			default: begin
				send_idle_pct = 14;
				recv_idle_pct = 14;
			end
		endcase
	endtask

	// mostly steady frame streams with jitter; the rest bursts, gaps, rewinds and noise
	task automatic fill_frames(input int nominal, input int count);
		int pick;
		int step;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				step = nominal + $urandom_range(0, 4) - 2;
				if (step < 0)
					step = 0;
				gen_ts = gen_ts + step;
			end else if (pick < 80) begin
				gen_ts = gen_ts + $urandom_range(0, 3);
			end else if (pick < 88) begin
				gen_ts = gen_ts + $urandom;
			end else if (pick < 94) begin
				gen_ts = gen_ts - $urandom_range(1, 1000);
			end else begin
				gen_ts = $urandom;
			end
			frames_pending.push_back(gen_ts);
		end
	endtask

	task automatic run_phase(input logic [RATE_W-1:0] cap, input logic [TPS_W-1:0] tps,
			input pacing_t mode, input int nominal, input int count);
		wait_drained();
		write_reg(REG_RATE_CAP, CFG_DATA_W'(cap));
		write_reg(REG_TPS, tps);
		settings_used++;
		set_pacing(mode);
		fill_frames(nominal, count);
		wait_drained();
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				rates_due.push_back(predict_rate(s_tdata));
				void'(frames_pending.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (frames_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= frames_pending[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (rates_due.size() == 0) begin
					report_mismatch($sformatf("shown_rate %0d with no frame outstanding",
						m_tdata[RATE_W-1:0]));
				end else begin
					due_rate = rates_due.pop_front();
					if (m_tdata[RATE_W-1:0] !== due_rate)
						report_mismatch($sformatf("shown_rate %0d, predicted %0d",
							m_tdata[RATE_W-1:0], due_rate));
					if (m_tdata[M_DATA_W-1:RATE_W] !== '0)
						report_mismatch($sformatf("tdata pad bits %h not zero",
							m_tdata[M_DATA_W-1:RATE_W]));
					results_checked++;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		for (int k = 0; k < WINDOW_LEN; k++)
			iv_ring[k] = '0;
		ring_pos = 0;
		iv_sum = '0;
		last_ts = '0;
		disp_rate = RATE_RESET;
		settled_rate = RATE_RESET;
		diff_count = '0;
		cap_reg = RATE_RESET;
		tps_reg = TPS_RESET;
		gen_ts = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: first frame from zero, saturation, wrap, rewind, bit patterns
		set_pacing(IDLE_NONE);
		frames_pending.push_back(32'h0000_0000);
		frames_pending.push_back(32'hFFFF_FFFF);
		frames_pending.push_back(32'h0000_0000);
		frames_pending.push_back(32'h0001_0000);
		frames_pending.push_back(32'h0000_8000);
		frames_pending.push_back(32'hAAAA_AAAA);
		frames_pending.push_back(32'h5555_5555);
		for (int k = 1; k <= 13; k++)
			frames_pending.push_back(32'h5555_5555 + 16 * k);
		gen_ts = 32'h5555_5555 + 16 * 13;
		wait_drained();

		run_phase(10'd0, 16'd0, IDLE_BOTH, 20, 20);
		run_phase(10'd1000, 16'd1000, IDLE_NONE, 16, 50);
		run_phase(10'd1000, 16'd65535, IDLE_SEND, 1, 60);
		run_phase(10'd1, 16'd65535, IDLE_RECV, 2, 40);
		run_phase(RATE_W'($urandom_range(1, 1000)), TPS_W'($urandom_range(1, 65535)),
			IDLE_NONE, $urandom_range(1, 50), 50);
		run_phase(10'd60, 16'd1000, IDLE_SEND, 33, 50);
		run_phase(10'd500, 16'd30000, IDLE_RECV, 40, 50);
		run_phase(RATE_W'($urandom_range(1, 1000)), TPS_W'($urandom_range(1, 65535)),
			IDLE_BOTH, $urandom_range(1, 50), 50);
		run_phase(10'd1000, 16'd1, IDLE_BOTH, 8, 30);

		$display("checked %0d shown_rate results over %0d register settings", results_checked,
			settings_used + 1);
		$display("pacing: free-running, sparse input, stalled output and light mixed gaps");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
